FILE: hdl/gah_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Shared constants and types: request kinds, result status codes and the
// layout of one slot entry in the slot table.
// ----------------------------------------------------------------------------
package gah_pkg;

   localparam int SLOTS_DEFAULT = 256;
   localparam int GEN_W         = 16;
   localparam int HANDLE_W      = 32;
   localparam int INDEX_W       = 8;

   localparam logic [GEN_W-1:0] GEN_MAX   = 16'hffff;
   localparam logic [GEN_W-1:0] GEN_FIRST = 16'd1;

   typedef enum logic [1:0] {
      KIND_ALLOC   = 2'd0,
      KIND_LOOKUP  = 2'd1,
      KIND_RELEASE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_STALE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic             live;
      logic [GEN_W-1:0] gen;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

FILE: hdl/gah_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module gah_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/generational_handle_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle allocator
// Allocates, checks and releases generational handles for a table of SLOTS
// slots held in a single synchronous RAM.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot table once, one slot per cycle, and
// holds busy high until the sweep ends and the first request can be taken.
// A lookup or release makes one RAM read, then checks the entry; a release
// also writes it back. An allocate reads the slot where its search starts
// and steps over each occupied slot while searching upward from the lowest
// slot that may be free: the slot after the last one allocated, or a lower
// slot released since then. An allocate on a full table does no search.
// Each result appears for one cycle with rsp_strobe and must be captured
// then, since the block cannot be stalled.
module generational_handle_allocator #(
   parameter int SLOTS = gah_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_kind,
   input  logic [gah_pkg::HANDLE_W-1:0]  req_handle,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_status,
   output logic [gah_pkg::HANDLE_W-1:0]  rsp_new_handle,
   output logic [gah_pkg::INDEX_W-1:0]   rsp_slot_index
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int GW = gah_pkg::GEN_W;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EVAL  = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [CW-1:0]      hint_ff, hint_in;
   logic [CW-1:0]      free_ff, free_in;
   gah_pkg::kind_type  kind_ff, kind_in;
   logic               range_ok_ff, range_ok_in;
   logic [GW-1:0]      req_gen_ff, req_gen_in;
   logic               kind_ok_ff, kind_ok_in;

   logic                         rsp_strobe_ff, rsp_strobe_in;
   gah_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [gah_pkg::HANDLE_W-1:0] rsp_new_handle_ff, rsp_new_handle_in;
   logic [gah_pkg::INDEX_W-1:0]  rsp_slot_index_ff, rsp_slot_index_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   gah_pkg::entry_type   wr_entry;
   logic [AW-1:0]        rd_addr;
   gah_pkg::entry_type   rd_entry;
   logic [gah_pkg::ENTRY_W-1:0] rd_raw;

   logic [GW-1:0]        req_low;
   logic                 req_in_range;
   logic [AW-1:0]        req_addr;
   logic [AW-1:0]        addr_next;
   logic [CW-1:0]        addr_wide;
   logic [31:0]          addr_ext;
   logic [GW-1:0]        gen_next;
   logic                 handle_ok;

   gah_ram #(
      .WIDTH (gah_pkg::ENTRY_W),
      .DEPTH (SLOTS),
      .ADDR_W(AW)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );

   assign rd_entry = gah_pkg::entry_type'(rd_raw);

   assign req_low      = req_handle[GW-1:0];
   assign req_in_range = (req_low != '0) && (32'(req_low) <= 32'(SLOTS));
   assign req_addr     = AW'(req_low - GW'(1));
   assign addr_next    = addr_ff + AW'(1);
   assign addr_wide    = CW'(addr_ff);
   assign addr_ext     = 32'(addr_ff);
   assign gen_next     = (rd_entry.gen == gah_pkg::GEN_MAX) ? gah_pkg::GEN_FIRST
                                                            : rd_entry.gen + GW'(1);
   assign handle_ok    = range_ok_ff && rd_entry.live && (rd_entry.gen == req_gen_ff);

   always_comb begin
      state_in          = state_ff;
      addr_in           = addr_ff;
      hint_in           = hint_ff;
      free_in           = free_ff;
      kind_in           = kind_ff;
      range_ok_in       = range_ok_ff;
      req_gen_in        = req_gen_ff;
      kind_ok_in        = kind_ok_ff;
      rsp_strobe_in     = 1'b0;
      rsp_status_in     = rsp_status_ff;
      rsp_new_handle_in = rsp_new_handle_ff;
      rsp_slot_index_in = rsp_slot_index_ff;
      wr_en             = 1'b0;
      wr_addr           = addr_ff;
      wr_entry          = rd_entry;
      rd_addr           = addr_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en         = 1'b1;
            wr_entry.live = 1'b0;
            wr_entry.gen  = gah_pkg::GEN_FIRST;
            addr_in       = addr_next;
            if (addr_ff == AW'(SLOTS - 1)) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            kind_ok_in  = (req_kind == gah_pkg::KIND_ALLOC)
                       || (req_kind == gah_pkg::KIND_LOOKUP)
                       || (req_kind == gah_pkg::KIND_RELEASE);
            if (req_kind == gah_pkg::KIND_ALLOC) begin
               rd_addr = AW'(hint_ff);
            end else begin
               rd_addr = req_addr;
            end
            if (start) begin
               kind_in     = gah_pkg::kind_type'(req_kind);
               range_ok_in = req_in_range;
               req_gen_in  = req_handle[gah_pkg::HANDLE_W-1:GW];
               addr_in     = rd_addr;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            rsp_strobe_in     = 1'b1;
            rsp_status_in     = gah_pkg::STATUS_STALE;
            rsp_new_handle_in = '0;
            rsp_slot_index_in = '0;
            state_in          = ST_IDLE;
            if (kind_ok_ff) begin
               unique case (kind_ff)
                  gah_pkg::KIND_ALLOC: begin
                     if (free_ff == '0) begin
                        rsp_status_in = gah_pkg::STATUS_FULL;
                     end else if (rd_entry.live) begin
                        rsp_strobe_in = 1'b0;
                        rd_addr       = addr_next;
                        addr_in       = addr_next;
                        state_in      = ST_EVAL;
                     end else begin
                        wr_en             = 1'b1;
                        wr_entry.live     = 1'b1;
                        hint_in           = addr_wide + CW'(1);
                        free_in           = free_ff - CW'(1);
                        rsp_status_in     = gah_pkg::STATUS_OK;
                        rsp_new_handle_in = {rd_entry.gen, GW'(addr_ext + 32'd1)};
                        rsp_slot_index_in = addr_ext[gah_pkg::INDEX_W-1:0];
                     end
                  end
                  gah_pkg::KIND_LOOKUP: begin
                     if (handle_ok) begin
                        rsp_status_in     = gah_pkg::STATUS_OK;
                        rsp_slot_index_in = addr_ext[gah_pkg::INDEX_W-1:0];
                     end
                  end
                  gah_pkg::KIND_RELEASE: begin
                     if (handle_ok) begin
                        wr_en             = 1'b1;
                        wr_entry.live     = 1'b0;
                        wr_entry.gen      = gen_next;
                        free_in           = free_ff + CW'(1);
                        if (addr_wide < hint_ff) begin
                           hint_in = addr_wide;
                        end
                        rsp_status_in     = gah_pkg::STATUS_OK;
                        rsp_slot_index_in = addr_ext[gah_pkg::INDEX_W-1:0];
                     end
                  end
                  default: begin
                     rsp_status_in = gah_pkg::STATUS_STALE;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         addr_ff       <= '0;
         hint_ff       <= '0;
         free_ff       <= CW'(SLOTS);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         hint_ff       <= hint_in;
         free_ff       <= free_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff           <= kind_in;
      range_ok_ff       <= range_ok_in;
      req_gen_ff        <= req_gen_in;
      kind_ok_ff        <= kind_ok_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_new_handle_ff <= rsp_new_handle_in;
      rsp_slot_index_ff <= rsp_slot_index_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_new_handle = rsp_new_handle_ff;
   assign rsp_slot_index = rsp_slot_index_ff;

endmodule

FILE: bench/generational_handle_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle allocator testbench
// Drives allocate, lookup, release and unknown requests into the handle table
// and compares every result with a cycle-free shadow of the slot table that
// tracks live bits and generations. The stimulus covers the corner handles,
// a full table, heavy churn with random gaps, and repeated reuse of one slot.
// ----------------------------------------------------------------------------
module generational_handle_allocator_test;

   localparam int SLOTS = gah_pkg::SLOTS_DEFAULT;
   localparam int HW = gah_pkg::HANDLE_W;
   localparam int IW = gah_pkg::INDEX_W;
   localparam int GW = gah_pkg::GEN_W;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int RANDOM_REQUESTS = 1400;
   localparam int REUSE_ROUNDS = 16;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   typedef enum {MODE_FILL, MODE_MIX, MODE_DRAIN} mode_type;

   class handle_scoreboard #(int N = 256);
      typedef struct {
         gah_pkg::status_type   status;
         logic [HW-1:0]         new_handle;
         logic [IW-1:0]         slot_index;
      } result_type;

      bit                slot_live [N];
      logic [GW-1:0]     slot_gen [N];
      result_type        owed_results [$];
      int unsigned       live_count;
      int unsigned       error_count;

      function new();
         for (int i = 0; i < N; i++) begin
            slot_live[i] = 1'b0;
            slot_gen[i] = gah_pkg::GEN_FIRST;
         end
         live_count = 0;
         error_count = 0;
      endfunction

      function int unsigned pending();
         return owed_results.size();
      endfunction

      function bit handle_matches(logic [HW-1:0] h, output int unsigned idx);
         int unsigned low;
         low = h[15:0];
         idx = 0;
         if (low == 0 || low > N) return 1'b0;
         idx = low - 1;
         return slot_live[idx] && (slot_gen[idx] == h[31:16]);
      endfunction

      // Updates the shadow table for one accepted request and queues the
      // result it must produce.
      function void note_request(logic [1:0] kind, logic [HW-1:0] h);
         result_type  r;
         int unsigned idx;
         r.status = gah_pkg::STATUS_STALE;
         r.new_handle = '0;
         r.slot_index = '0;
         case (kind)
            gah_pkg::KIND_ALLOC: begin
               r.status = gah_pkg::STATUS_FULL;
               for (int i = 0; i < N; i++) begin
                  if (!slot_live[i]) begin
                     slot_live[i] = 1'b1;
                     live_count++;
                     r.status = gah_pkg::STATUS_OK;
                     r.new_handle = {slot_gen[i], 16'(i + 1)};
                     r.slot_index = 8'(i);
                     break;
                  end
               end
            end
            gah_pkg::KIND_LOOKUP: begin
               if (handle_matches(h, idx)) begin
                  r.status = gah_pkg::STATUS_OK;
                  r.slot_index = 8'(idx);
               end
            end
            gah_pkg::KIND_RELEASE: begin
               if (handle_matches(h, idx)) begin
                  slot_live[idx] = 1'b0;
                  live_count--;
                  slot_gen[idx] = (slot_gen[idx] == gah_pkg::GEN_MAX) ? gah_pkg::GEN_FIRST
                                                                      : slot_gen[idx] + 1'b1;
                  r.status = gah_pkg::STATUS_OK;
                  r.slot_index = 8'(idx);
               end
            end
            default: ;
         endcase
         owed_results.insert(owed_results.size(), r);
      endfunction

      task report_mismatch(string what, logic [HW-1:0] got, logic [HW-1:0] want);
         error_count++;
         $display("%0t mismatch on %s: got %h, wanted %h", $time, what, got, want);
      endtask

      task check_result(logic [1:0] status, logic [HW-1:0] nh, logic [IW-1:0] idx);
         result_type want;
         if (owed_results.size() == 0) begin
            report_mismatch("result with no request outstanding", {30'd0, status}, '0);
            return;
         end
         want = owed_results.pop_front();
         if (status !== want.status)
            report_mismatch("status", {30'd0, status}, {30'd0, want.status});
         if (nh !== want.new_handle)
            report_mismatch("new_handle", nh, want.new_handle);
         if (idx !== want.slot_index)
            report_mismatch("slot_index", {24'd0, idx}, {24'd0, want.slot_index});
      endtask

      function logic [HW-1:0] live_handle();
         int unsigned s;
         if (live_count == 0) return $urandom();
         s = $urandom_range(0, N - 1);
         while (!slot_live[s]) s = (s + 1) % N;
         return {slot_gen[s], 16'(s + 1)};
      endfunction

      // Handles that are mostly wrong: bad generation, older generation,
      // zero or out-of-range slot, or a slot that may have been freed.
      function logic [HW-1:0] bent_handle();
         int unsigned s;
         logic [HW-1:0] h;
         s = $urandom_range(0, N - 1);
         case ($urandom_range(0, 5))
            0: h = $urandom();
            1: h = {slot_gen[s] ^ 16'($urandom_range(1, 65535)), 16'(s + 1)};
            2: h = {slot_gen[s] - 16'd1, 16'(s + 1)};
            3: h = {16'($urandom()), 16'd0};
            4: h = {16'($urandom()), 16'($urandom_range(N + 1, 65535))};
            default: h = {slot_gen[s], 16'(s + 1)};
         endcase
         return h;
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_kind;
   logic [HW-1:0]         req_handle;
   logic                  rsp_strobe;
   logic [1:0]            rsp_status;
   logic [HW-1:0]         rsp_new_handle;
   logic [IW-1:0]         rsp_slot_index;

   handle_scoreboard #(SLOTS) sb;
   int unsigned cycle_count = 0;

   generational_handle_allocator #(.SLOTS(SLOTS)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_handle     (req_handle),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_new_handle (rsp_new_handle),
      .rsp_slot_index (rsp_slot_index)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("generational_handle_allocator_test: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         sb.check_result(rsp_status, rsp_new_handle, rsp_slot_index);
   end

   // Entered and left on a rising edge. Start stays high across back-to-back
   // requests so that it is never lowered and raised in the same step.
   task automatic send_request(logic [1:0] kind, logic [HW-1:0] h, int unsigned gap);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_handle <= h;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(kind, h);
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic random_request(mode_type mode, int unsigned gap);
      int unsigned roll;
      int unsigned alloc_pct;
      int unsigned release_pct;
      logic [1:0]  kind;
      case (mode)
         MODE_FILL: begin
            alloc_pct = 80;
            release_pct = 5;
         end
         MODE_DRAIN: begin
            alloc_pct = 10;
            release_pct = 70;
         end
         default: begin
            alloc_pct = 35;
            release_pct = 30;
         end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct)
         send_request(gah_pkg::KIND_ALLOC, $urandom(), gap);
      else if (roll < alloc_pct + release_pct)
         send_request(gah_pkg::KIND_RELEASE, sb.live_handle(), gap);
      else if ($urandom_range(0, 1) == 0)
         send_request(gah_pkg::KIND_LOOKUP, sb.live_handle(), gap);
      else begin
         case ($urandom_range(0, 4))
            0, 1: kind = gah_pkg::KIND_LOOKUP;
            2, 3: kind = gah_pkg::KIND_RELEASE;
            default: kind = KIND_UNKNOWN;
         endcase
         send_request(kind, sb.bent_handle(), gap);
      end
   endtask

   initial begin
      mode_type            mode;
      int unsigned         gap;
      logic [HW-1:0]       old_handle;

      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_kind = gah_pkg::KIND_ALLOC;
      req_handle = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_request(gah_pkg::KIND_LOOKUP,  32'h0000_0000, $urandom_range(0, 5));
      send_request(gah_pkg::KIND_RELEASE, 32'hffff_ffff, $urandom_range(0, 5));
      send_request(gah_pkg::KIND_ALLOC,   32'h0000_0000, $urandom_range(0, 5));
      send_request(gah_pkg::KIND_ALLOC,   32'h1234_5678, $urandom_range(0, 5));
      send_request(gah_pkg::KIND_LOOKUP,  32'h0001_0001, $urandom_range(0, 5));
      send_request(gah_pkg::KIND_LOOKUP,  32'h0002_0001, $urandom_range(0, 5));
      send_request(gah_pkg::KIND_LOOKUP,  32'h0001_0003, $urandom_range(0, 5));
      send_request(gah_pkg::KIND_LOOKUP,  32'h0001_0101, $urandom_range(0, 5));
      send_request(gah_pkg::KIND_LOOKUP,  32'h0001_0100, $urandom_range(0, 5));
      send_request(KIND_UNKNOWN,          32'h0001_0001, $urandom_range(0, 5));
      send_request(gah_pkg::KIND_RELEASE, 32'h0001_0001, 0);
      send_request(gah_pkg::KIND_RELEASE, 32'h0001_0001, 0);
      send_request(gah_pkg::KIND_LOOKUP,  32'h0001_0001, 0);
      send_request(gah_pkg::KIND_ALLOC,   32'hffff_ffff, $urandom_range(0, 5));
      send_request(gah_pkg::KIND_ALLOC,   32'h0000_0000, 0);
      send_request(gah_pkg::KIND_RELEASE, 32'h0001_0002, $urandom_range(0, 5));
      send_request(gah_pkg::KIND_RELEASE, 32'h0002_0001, $urandom_range(0, 5));
      send_request(gah_pkg::KIND_LOOKUP,  32'h0000_0001, $urandom_range(0, 5));
      send_request(gah_pkg::KIND_LOOKUP,  32'hffff_0000, $urandom_range(0, 5));
      send_request(gah_pkg::KIND_ALLOC,   $urandom(), $urandom_range(0, 5));
      hold_until_drained();

      while (sb.live_count < SLOTS)
         send_request(gah_pkg::KIND_ALLOC, $urandom(), $urandom_range(0, 2));
      repeat (3) send_request(gah_pkg::KIND_ALLOC, $urandom(), $urandom_range(0, 5));
      send_request(gah_pkg::KIND_LOOKUP, {sb.slot_gen[SLOTS-1], 16'(SLOTS)},
                   $urandom_range(0, 5));
      send_request(gah_pkg::KIND_RELEASE, {sb.slot_gen[SLOTS-1], 16'(SLOTS)}, 0);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         case ((n / 150) % 4)
            0: mode = MODE_DRAIN;
            2: mode = MODE_FILL;
            default: mode = MODE_MIX;
         endcase
         gap = ((n / 60) % 3 == 2) ? 0 : $urandom_range(0, 5);
         random_request(mode, gap);
         if (n % 400 == 399) hold_until_drained();
      end

      // Reuse slot zero several times so that its older handles go stale.
      if (!sb.slot_live[0])
         send_request(gah_pkg::KIND_ALLOC, $urandom(), 0);
      old_handle = {sb.slot_gen[0], 16'd1};
      repeat (REUSE_ROUNDS) begin
         old_handle = {sb.slot_gen[0], 16'd1};
         send_request(gah_pkg::KIND_RELEASE, old_handle, 0);
         send_request(gah_pkg::KIND_ALLOC, $urandom(), 0);
      end
      send_request(gah_pkg::KIND_LOOKUP, old_handle, $urandom_range(0, 5));
      send_request(gah_pkg::KIND_LOOKUP, {gah_pkg::GEN_MAX, 16'd1}, $urandom_range(0, 5));
      send_request(gah_pkg::KIND_LOOKUP, {sb.slot_gen[0], 16'd1}, $urandom_range(0, 5));
      send_request(gah_pkg::KIND_RELEASE, {sb.slot_gen[0], 16'd1}, $urandom_range(0, 5));

      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.error_count == 0)
         $display("generational_handle_allocator_test: clean");
      else
         $display("generational_handle_allocator_test: errors");
      $finish;
   end

endmodule
